[sv/msa_pkg.sv]
package msa_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int XW          = $clog2(GRID_WIDTH);
  localparam int YW          = $clog2(GRID_HEIGHT);
  localparam int AW          = XW + YW;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_GEN   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_CLEAR,
    ST_OUT
  } state_t;

  typedef logic [1:0] cell_t;

  function automatic logic [7:0] apply_rules(input logic [7:0] blk);
    cell_t a, b, c, d;
    logic [7:0] res;
    begin
      a = blk[1:0];
      b = blk[3:2];
      c = blk[5:4];
      d = blk[7:6];
      res = blk;
      if (a == 2'd1 && b == 2'd1 && c == 2'd0 && d == 2'd0)
        res = {2'd1, 2'd1, 2'd0, 2'd0};
      else if (a == 2'd1 && c == 2'd0)
        res = {d, 2'd1, b, 2'd0};
      else if (b == 2'd1 && d == 2'd0)
        res = {2'd1, c, 2'd0, a};
      else if (a == 2'd1 && b == 2'd0 && d == 2'd0)
        res = {2'd1, c, 2'd0, 2'd0};
      else if (b == 2'd1 && a == 2'd0 && c == 2'd0)
        res = {d, 2'd1, 2'd0, 2'd0};
      else if (a == 2'd3 && c == 2'd0)
        res = {d, 2'd1, b, 2'd3};
      else if (b == 2'd3 && d == 2'd0)
        res = {2'd1, c, 2'd3, a};
      apply_rules = res;
    end
  endfunction

endpackage

[sv/margolus_sand_automaton_top.sv]
// a generation sweeps 4096 blocks, each in steps: four reads, a wait for the last
// read data, four writes through the one-read one-write cell memory
// one item at a time: the next beat is taken the cycle after the result beat
// reset: phase zero, then a clearing pass over all 16384 cells with in_ready low
module margolus_sand_automaton_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [msa_pkg::XW-1:0] x,
  input  logic [msa_pkg::YW-1:0] y,
  input  logic [1:0]            value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            cell_value,
  output logic                  phase
);
  import msa_pkg::*;

  localparam logic [3:0] STEP_WR   = 4'd5;
  localparam logic [3:0] STEP_LAST = 4'd8;

  state_t state, state_next;
  logic [AW-1:0] clr_cnt;
  logic [XW-1:0] bx;
  logic [YW-1:0] by;
  logic [3:0]    step;
  logic [7:0]    blk, res;
  logic          last_col, last_row;
  logic [1:0]    sel;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [AW-1:0] cell_addr;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    wdata, rdata;
  logic          accept;

  msa_grid_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign res = apply_rules(blk);
  assign last_col = &bx[XW-1:1];
  assign last_row = &by[YW-1:1];
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  // cell of the current block: bit 0 picks the right column, bit 1 the lower row
  always_comb begin
    sel = (step >= STEP_WR) ? 2'(step - STEP_WR) : step[1:0];
    cx = sel[0] ? bx + XW'(1) : bx;
    cy = sel[1] ? by + YW'(1) : by;
    cell_addr = {cy, cx};
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = cell_addr;
    wdata = 2'd0;
    raddr = cell_addr;
    case (state)
      ST_INIT: begin
        we = 1'b1;
        waddr = clr_cnt;
        if (&clr_cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        raddr = {y, x};
        if (accept) begin
          case (command)
            CMD_WRITE: begin
              we = 1'b1;
              waddr = {y, x};
              wdata = value;
              state_next = ST_OUT;
            end
            CMD_READ:  state_next = ST_READ;
            CMD_GEN:   state_next = ST_GEN;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_OUT;
      ST_GEN: begin
        we = (step >= STEP_WR);
        wdata = res[{sel, 1'b0} +: 2];
        if (step == STEP_LAST && last_col && last_row) state_next = ST_OUT;
      end
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt;
        if (&clr_cnt) state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      clr_cnt <= '0;
      phase <= 1'b0;
      out_valid <= 1'b0;
      cell_value <= 2'd0;
      step <= '0;
      bx <= '0;
      by <= '0;
      blk <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_INIT, ST_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        ST_IDLE: begin
          step <= '0;
          bx <= XW'(phase);
          by <= YW'(phase);
          if (accept) cell_value <= 2'd0;
        end
        ST_READ: cell_value <= rdata;
        ST_GEN: begin
          if (step >= 4'd1 && step <= 4'd4)
            blk[{2'(step - 4'd1), 1'b0} +: 2] <= rdata;
          if (step == STEP_LAST) begin
            step <= '0;
            if (last_col) begin
              bx <= XW'(phase);
              by <= by + YW'(2);
            end else begin
              bx <= bx + XW'(2);
            end
            if (last_col && last_row) phase <= ~phase;
          end else begin
            step <= step + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[sv/msa_grid_mem.sv]
module msa_grid_mem #(
  parameter int DEPTH = 16384,
  parameter int AW = 14
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [1:0]           wdata,
  input  logic [AW-1:0]        raddr,
  output logic [1:0]           rdata
);
  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[tb/sv/margolus_sand_automaton_top_tb.sv]
module margolus_sand_automaton_top_tb;
  import msa_pkg::*;

  localparam int W = GRID_WIDTH;
  localparam int H = GRID_HEIGHT;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int ANY = -1;
  localparam int RULE_IN [4][4] = '{'{1, 1, 0, 0}, '{1, ANY, 0, ANY},
                                    '{1, 0, ANY, 0}, '{3, ANY, 0, ANY}};
  localparam int RULE_OUT [4][4] = '{'{0, 0, 1, 1}, '{0, ANY, 1, ANY},
                                     '{0, 0, ANY, 1}, '{3, ANY, 1, ANY}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_READ;
  logic [6:0] x = '0;
  logic [6:0] y = '0;
  logic [1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] cell_value;
  logic phase;

  cell_t sand_grid [0:W*H-1];
  cell_t sand_next [0:W*H-1];
  logic grid_phase;
  cell_t want_cell [$];
  logic want_phase [$];
  int send_idle = 0;
  int recv_idle = 0;
  int stall_len = 0;
  int stall_tok = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int gens_run = 0;

  margolus_sand_automaton_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .x(x), .y(y), .value(value), .out_valid(out_valid),
    .out_ready(out_ready), .cell_value(cell_value), .phase(phase)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random idling plus long hold-off on request
  always @(posedge clk) begin
    if (stall_tok != stall_seen) begin
      stall_seen <= stall_tok;
      stall_left <= stall_len;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (want_cell.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: cell %0d phase %0d", cell_value, phase);
      end else begin
        cell_t ec;
        logic ep;
        ec = want_cell.pop_front();
        ep = want_phase.pop_front();
        if (ec !== cell_value || ep !== phase) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: cell exp %0d got %0d, phase exp %0d got %0d",
                     ec, cell_value, ep, phase);
        end
      end
    end
  end

  function automatic bit rule_fits(int r, cell_t b [4]);
    for (int i = 0; i < 4; i++)
      if (RULE_IN[r][i] != ANY && RULE_IN[r][i] != b[i]) return 0;
    return 1;
  endfunction

  function automatic void settle_sand();
    int ph;
    ph = grid_phase;
    for (int i = 0; i < W*H; i++) sand_next[i] = sand_grid[i];
    for (int by = ph; by < H + ph; by += 2) begin
      for (int bx = ph; bx < W + ph; bx += 2) begin
        int pos [4];
        cell_t blk [4];
        cell_t mir [4];
        cell_t res [4];
        bit hit;
        pos[0] = (by % H) * W + (bx % W);
        pos[1] = (by % H) * W + ((bx + 1) % W);
        pos[2] = ((by + 1) % H) * W + (bx % W);
        pos[3] = ((by + 1) % H) * W + ((bx + 1) % W);
        for (int i = 0; i < 4; i++) blk[i] = sand_grid[pos[i]];
        mir[0] = blk[1]; mir[1] = blk[0]; mir[2] = blk[3]; mir[3] = blk[2];
        hit = 0;
        for (int r = 0; r < 4 && !hit; r++) begin
          if (rule_fits(r, blk)) begin
            for (int i = 0; i < 4; i++)
              res[i] = (RULE_OUT[r][i] == ANY) ? blk[i] : cell_t'(RULE_OUT[r][i]);
            hit = 1;
          end else if (rule_fits(r, mir)) begin
            for (int i = 0; i < 4; i++)
              res[i ^ 1] = (RULE_OUT[r][i] == ANY) ? mir[i] : cell_t'(RULE_OUT[r][i]);
            hit = 1;
          end
        end
        if (hit) for (int i = 0; i < 4; i++) sand_next[pos[i]] = res[i];
      end
    end
    for (int i = 0; i < W*H; i++) sand_grid[i] = sand_next[i];
    grid_phase = ~grid_phase;
  endfunction

  task automatic send_beat(cmd_t c, int cx, int cy, int v);
    cell_t got;
    int idx;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    x <= cx[6:0];
    y <= cy[6:0];
    value <= v[1:0];
    do @(posedge clk); while (!in_ready);
    beats_in++;
    idx = (cy % H) * W + (cx % W);
    got = '0;
    case (c)
      CMD_WRITE: sand_grid[idx] = v[1:0];
      CMD_READ:  got = sand_grid[idx];
      CMD_GEN: begin
        settle_sand();
        gens_run++;
      end
      default: for (int i = 0; i < W*H; i++) sand_grid[i] = '0;
    endcase
    want_cell = {want_cell, got};
    want_phase = {want_phase, grid_phase};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_cell.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_cell_access();
    send_beat(CMD_READ, 5, 9, 0);
    send_beat(CMD_WRITE, 0, 0, 3);
    send_beat(CMD_WRITE, 127, 127, 2);
    send_beat(CMD_WRITE, 127, 0, 1);
    send_beat(CMD_READ, 0, 0, 0);
    send_beat(CMD_READ, 127, 127, 3);
    send_beat(CMD_READ, 127, 0, 0);
    send_beat(CMD_WRITE, 127, 127, 0);
    send_beat(CMD_READ, 127, 127, 0);
    send_beat(CMD_CLEAR, 0, 0, 0);
    send_beat(CMD_READ, 0, 0, 0);
  endtask

  task automatic test_sand_rules();
    send_beat(CMD_WRITE, 0, 0, 1);
    send_beat(CMD_WRITE, 1, 0, 1);
    send_beat(CMD_WRITE, 3, 0, 1);
    send_beat(CMD_WRITE, 4, 0, 1);
    send_beat(CMD_WRITE, 4, 1, 2);
    send_beat(CMD_WRITE, 7, 0, 3);
    send_beat(CMD_GEN, 0, 0, 0);
    for (int cx = 0; cx < 8; cx += 3) send_beat(CMD_READ, cx, 1, 0);
    send_beat(CMD_READ, 5, 1, 0);
    send_beat(CMD_READ, 6, 1, 0);
  endtask

  task automatic test_seam_wrap();
    send_beat(CMD_WRITE, 127, 127, 1);
    send_beat(CMD_GEN, 0, 0, 0);
    send_beat(CMD_READ, 127, 0, 0);
    send_beat(CMD_READ, 127, 127, 0);
  endtask

  task automatic test_stall_pressure();
    stall_len = 300;
    stall_tok++;
    for (int i = 0; i < 6; i++) send_beat(CMD_READ, $urandom_range(127), $urandom_range(127), 0);
    drain();
  endtask

  task automatic test_random_mix(int n, int s_idle, int r_idle);
    int sent;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n) begin
      int bx, by, roll;
      roll = $urandom_range(99);
      bx = (roll < 30) ? 124 + $urandom_range(3) : $urandom_range(127);
      by = ($urandom_range(3) == 0) ? 124 + $urandom_range(3) : $urandom_range(127);
      if (roll < 8) begin
        // noise
        send_beat(cmd_t'($urandom_range(3) == 0 ? CMD_CLEAR : CMD_READ),
                  $urandom_range(127), $urandom_range(127), $urandom_range(3));
        sent++;
      end else begin
        int nw, ng;
        nw = 3 + $urandom_range(5);
        for (int i = 0; i < nw; i++) begin
          int v;
          v = $urandom_range(9);
          v = (v < 5) ? 1 : (v < 7) ? 0 : (v < 8) ? 2 : 3;
          send_beat(CMD_WRITE, (bx + $urandom_range(3)) % W, (by + $urandom_range(3)) % H, v);
        end
        ng = ($urandom_range(3) == 0) ? 2 : 1;
        for (int i = 0; i < ng; i++) send_beat(CMD_GEN, $urandom_range(127), $urandom_range(127),
                                               $urandom_range(3));
        for (int i = 0; i < 4; i++)
          send_beat(CMD_READ, (bx + $urandom_range(3)) % W, (by + $urandom_range(4)) % H,
                    $urandom_range(3));
        sent += nw + ng + 4;
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < W*H; i++) sand_grid[i] = '0;
    grid_phase = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_cell_access();
    test_sand_rules();
    test_seam_wrap();
    drain();
    test_stall_pressure();
    test_random_mix(33, 30, 86);
    test_random_mix(33, 86, 30);
    test_random_mix(33, 0, 0);
    $display("beats sent %0d, results checked %0d, generations %0d, mismatches %0d",
             beats_in, beats_out, gens_run, mismatches);
    $display("covered cell access at the grid edges, all sand rules and mirrors, seam wrap");
    if (mismatches == 0 && want_cell.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[margolus_sand_automaton_top.f]
sv/msa_pkg.sv
sv/msa_grid_mem.sv
sv/margolus_sand_automaton_top.sv
tb/sv/margolus_sand_automaton_top_tb.sv
